// ===== design/sset_pkg.sv =====
// Shared types, constants and helpers for the SSE event stream tokenizer.
`default_nettype none

package sset_pkg;

   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int EVENT_LEN   = 6;
   localparam int DATA_LEN    = 5;

   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

   typedef enum logic [1:0] {
      TK_RESTART  = 2'd0,
      TK_EVENT    = 2'd1,
      TK_DATA     = 2'd2,
      TK_DISPATCH = 2'd3
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic              dflt;
   } token_type;

   // One queue entry: the tokens caused by one accepted item
   typedef struct packed {
      token_type first;
      token_type second;
      logic      pair;
   } entry_type;

   // Character of the "event:" (kind 0) or "data:" (kind 1) prefix at a position
   function automatic logic [BYTE_W-1:0] prefix_char(input logic kind, input logic [2:0] pos);
      logic [BYTE_W-1:0] ch;
      ch = '0;
      if (!kind) begin
         case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h76;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            3'd5:    ch = CH_COLON;
            default: ch = '0;
         endcase
      end else begin
         case (pos)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = CH_COLON;
            default: ch = '0;
         endcase
      end
      return ch;
   endfunction

   function automatic token_type mk_tok(input tok_kind_type kind,
                                        input logic [BYTE_W-1:0] data,
                                        input logic dflt);
      token_type t;
      t.kind = kind;
      t.data = data;
      t.dflt = dflt;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== design/sset_req_if.sv =====
// Request channel: one stream byte or a finish marker per transfer.
`default_nettype none

interface sset_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [sset_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== design/sset_rsp_if.sv =====
// Response channel: one tagged token per transfer.
`default_nettype none

interface sset_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   token_kind;
   logic [sset_pkg::BYTE_W-1:0]  token_byte;
   logic                         default_name;
   logic                         last;

   modport source (output valid, output token_kind, output token_byte,
                   output default_name, output last, input ready);
   modport sink   (input valid, input token_kind, input token_byte,
                   input default_name, input last, output ready);
endinterface

`default_nettype wire

// ===== design/sset_front.sv =====
// Front end: accepts bytes, tracks line state and classifies each byte into tokens.
`default_nettype none

module sset_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_action,
   input  wire logic [sset_pkg::BYTE_W-1:0] req_in_byte,
   output logic                             req_ready,
   input  wire logic                        room,
   output logic                             push,
   output sset_pkg::entry_type              entry
);
   import sset_pkg::*;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PREFIX = 3'd1,
      PH_SKIP   = 3'd2,
      PH_VALUE  = 3'd3,
      PH_IGNORE = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic        kind_ff, kind_in;
   logic        cr_ff, cr_in;
   logic        dne_ff, dne_in;
   logic        ene_ff, ene_in;

   logic        accept;
   logic        e0_v, e1_v;
   token_type   t0, t1;
   tok_kind_type val_kind;
   logic [2:0]  plen;
   logic [2:0]  pos_inc;
   logic        match;
   logic [BYTE_W-1:0] b;

   assign req_ready = room;
   assign accept    = req_valid && room;
   assign b         = req_in_byte;
   assign val_kind  = kind_ff ? TK_DATA : TK_EVENT;
   assign plen      = kind_ff ? 3'(DATA_LEN) : 3'(EVENT_LEN);
   assign pos_inc   = pos_ff + 3'd1;
   assign match     = (pos_ff < plen) && (b == prefix_char(kind_ff, pos_ff));

   // Work out the next line state and the tokens for this item
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      cr_in    = cr_ff;
      dne_in   = dne_ff;
      ene_in   = ene_ff;
      e0_v     = 1'b0;
      e1_v     = 1'b0;
      t0       = mk_tok(TK_RESTART, '0, 1'b0);
      t1       = mk_tok(TK_RESTART, '0, 1'b0);

      if (req_action) begin
         // Finish: close a lone CR line as blank, then flush pending data
         if (phase_ff == PH_START && cr_ff && (dne_ff || ene_ff)) begin
            e0_v   = 1'b1;
            t0     = mk_tok(TK_DISPATCH, '0, 1'b0);
            dne_in = 1'b0;
            ene_in = 1'b0;
         end else if (dne_ff) begin
            e0_v   = 1'b1;
            t0     = mk_tok(TK_DISPATCH, '0, 1'b1);
            dne_in = 1'b0;
            ene_in = 1'b0;
         end
         phase_in = PH_START;
         pos_in   = '0;
         cr_in    = 1'b0;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (cr_ff) begin
                  cr_in = 1'b0;
                  if (b == CH_LF) begin
                     if (dne_ff || ene_ff) begin
                        e0_v   = 1'b1;
                        t0     = mk_tok(TK_DISPATCH, '0, 1'b0);
                        dne_in = 1'b0;
                        ene_in = 1'b0;
                     end
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end else if (b == CH_LF) begin
                  if (dne_ff || ene_ff) begin
                     e0_v   = 1'b1;
                     t0     = mk_tok(TK_DISPATCH, '0, 1'b0);
                     dne_in = 1'b0;
                     ene_in = 1'b0;
                  end
               end else if (b == CH_CR) begin
                  cr_in = 1'b1;
               end else if (b == prefix_char(1'b0, 3'd0)) begin
                  phase_in = PH_PREFIX;
                  kind_in  = 1'b0;
                  pos_in   = 3'd1;
               end else if (b == prefix_char(1'b1, 3'd0)) begin
                  phase_in = PH_PREFIX;
                  kind_in  = 1'b1;
                  pos_in   = 3'd1;
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
            PH_PREFIX: begin
               if (match) begin
                  pos_in = pos_inc;
                  if (pos_inc == plen) begin
                     phase_in = PH_SKIP;
                     cr_in    = 1'b0;
                     if (!kind_ff) begin
                        e0_v   = 1'b1;
                        t0     = mk_tok(TK_RESTART, '0, 1'b0);
                        ene_in = 1'b0;
                     end else if (dne_ff) begin
                        e0_v = 1'b1;
                        t0   = mk_tok(TK_DATA, CH_LF, 1'b0);
                     end
                  end
               end else if (b == CH_LF) begin
                  phase_in = PH_START;
                  pos_in   = '0;
                  cr_in    = 1'b0;
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
            PH_SKIP: begin
               if (cr_ff) begin
                  if (b == CH_LF) begin
                     phase_in = PH_START;
                     pos_in   = '0;
                     cr_in    = 1'b0;
                  end else begin
                     // Release the held CR, then treat this byte as a value byte
                     e0_v     = 1'b1;
                     t0       = mk_tok(val_kind, CH_CR, 1'b0);
                     phase_in = PH_VALUE;
                     if (kind_ff) dne_in = 1'b1;
                     else         ene_in = 1'b1;
                     if (b == CH_CR) begin
                        cr_in = 1'b1;
                     end else begin
                        cr_in = 1'b0;
                        e1_v  = 1'b1;
                        t1    = mk_tok(val_kind, b, 1'b0);
                     end
                  end
               end else if (b == CH_SPACE || b == CH_TAB) begin
                  phase_in = PH_SKIP;
               end else if (b == CH_LF) begin
                  phase_in = PH_START;
                  pos_in   = '0;
               end else if (b == CH_CR) begin
                  cr_in = 1'b1;
               end else begin
                  phase_in = PH_VALUE;
                  e0_v     = 1'b1;
                  t0       = mk_tok(val_kind, b, 1'b0);
                  if (kind_ff) dne_in = 1'b1;
                  else         ene_in = 1'b1;
               end
            end
            PH_VALUE: begin
               if (b == CH_LF) begin
                  phase_in = PH_START;
                  pos_in   = '0;
                  cr_in    = 1'b0;
               end else if (b == CH_CR) begin
                  // A second CR releases the one held before it
                  if (cr_ff) begin
                     e0_v = 1'b1;
                     t0   = mk_tok(val_kind, CH_CR, 1'b0);
                     if (kind_ff) dne_in = 1'b1;
                     else         ene_in = 1'b1;
                  end
                  cr_in = 1'b1;
               end else begin
                  if (kind_ff) dne_in = 1'b1;
                  else         ene_in = 1'b1;
                  if (cr_ff) begin
                     e0_v  = 1'b1;
                     t0    = mk_tok(val_kind, CH_CR, 1'b0);
                     e1_v  = 1'b1;
                     t1    = mk_tok(val_kind, b, 1'b0);
                     cr_in = 1'b0;
                  end else begin
                     e0_v = 1'b1;
                     t0   = mk_tok(val_kind, b, 1'b0);
                  end
               end
            end
            default: begin
               // Ignore the rest of the line
               phase_in = PH_IGNORE;
               cr_in    = 1'b0;
               if (b == CH_LF) begin
                  phase_in = PH_START;
                  pos_in   = '0;
               end
            end
         endcase
      end
   end

   // Queue only items that cause at least one token
   assign push         = accept && e0_v;
   assign entry.first  = t0;
   assign entry.second = t1;
   assign entry.pair   = e1_v;

   // Hold line state; advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         kind_ff  <= 1'b0;
         cr_ff    <= 1'b0;
         dne_ff   <= 1'b0;
         ene_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         cr_ff    <= cr_in;
         dne_ff   <= dne_in;
         ene_ff   <= ene_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sset_fifo.sv =====
// Short queue of token entries between the front and back ends.
`default_nettype none

module sset_fifo #(
   parameter int DEPTH = sset_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sset_pkg::entry_type entry_in,
   output logic                     room,
   input  wire logic                pop,
   output sset_pkg::entry_type      head,
   output logic                     not_empty
);
   import sset_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign room      = (cnt_ff != FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop)      cnt_in = cnt_ff + CNT_W'(1);
      else if (!push && pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entry payload
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= entry_in;
   end

endmodule

`default_nettype wire

// ===== design/sset_back.sv =====
// Back end: unpacks queued entries into single tokens behind an output register.
`default_nettype none

module sset_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sset_pkg::entry_type         head,
   input  wire logic                        not_empty,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_token_kind,
   output logic [sset_pkg::BYTE_W-1:0]      rsp_token_byte,
   output logic                             rsp_default_name,
   output logic                             rsp_last
);
   import sset_pkg::*;

   logic      valid_ff;
   logic      second_ff;
   token_type tok_ff;
   logic      last_ff;
   logic      load;

   // Load a new token whenever the output register is empty or being taken
   assign load = not_empty && (!valid_ff || rsp_ready);
   assign pop  = load && (second_ff || !head.pair);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff  <= 1'b1;
         second_ff <= !second_ff && head.pair;
      end else if (rsp_ready) begin
         valid_ff  <= 1'b0;
      end
   end

   // Hold token payload until transfer
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= second_ff ? head.second : head.first;
         last_ff <= second_ff || !head.pair;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_byte   = tok_ff.data;
   assign rsp_default_name = tok_ff.dflt;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// ===== design/sse_event_stream_tokenizer_top.sv =====
// Top level of the SSE event stream tokenizer: front end, token queue, back end.
//
//   Channel | Dir | Payload                                       | Handshake
//   req_if  | in  | action, in_byte                               | valid/ready
//   rsp_if  | out | token_kind, token_byte, default_name, last    | valid/ready
//
// One item is taken per cycle while the token queue has room; each item is
// classified in the cycle it is taken and its tokens are queued as one entry.
// The back end sends one token per cycle while rsp ready is high, so an item that
// causes two tokens takes two transfers; the queue of DEPTH entries absorbs bursts.
// A first token is offered only after its entry passes the queue and the output register.
// Synchronous reset clears line state, queue pointers and the output register.
// A stalled output fills the queue, after which req ready drops.
`default_nettype none

module sse_event_stream_tokenizer_top #(
   parameter int DEPTH = sset_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sset_req_if.sink   req_if,
   sset_rsp_if.source rsp_if
);
   import sset_pkg::*;

   logic      room;
   logic      push;
   entry_type entry;
   logic      pop;
   entry_type head;
   logic      not_empty;

   sset_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_action  (req_if.action),
      .req_in_byte (req_if.in_byte),
      .req_ready   (req_if.ready),
      .room        (room),
      .push        (push),
      .entry       (entry)
   );

   sset_fifo #(.DEPTH(DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (entry),
      .room      (room),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty)
   );

   sset_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .not_empty        (not_empty),
      .pop              (pop),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_token_kind   (rsp_if.token_kind),
      .rsp_token_byte   (rsp_if.token_byte),
      .rsp_default_name (rsp_if.default_name),
      .rsp_last         (rsp_if.last)
   );

endmodule

`default_nettype wire

// ===== design/sset_checker.sv =====
// Port-level checks on the tokenizer's response channel, bound to the top level.
`default_nettype none

module sset_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [1:0]                  rsp_token_kind,
   input wire logic [sset_pkg::BYTE_W-1:0] rsp_token_byte,
   input wire logic                        rsp_default_name,
   input wire logic                        rsp_last
);
   import sset_pkg::*;

   // Hold a stalled token
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_byte) && $stable(rsp_default_name) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Default name only rides on a dispatch
   a_dflt_dispatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_default_name |-> rsp_token_kind == TK_DISPATCH)
      else $error("default name on a non-dispatch token");

   // Restart and dispatch carry no byte
   a_ctrl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == TK_RESTART || rsp_token_kind == TK_DISPATCH)
         |-> rsp_token_byte == '0)
      else $error("control token with nonzero byte");

   // Restart and dispatch are always the only token of their item
   a_ctrl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == TK_RESTART || rsp_token_kind == TK_DISPATCH)
         |-> rsp_last)
      else $error("control token not marked last");

endmodule

bind sse_event_stream_tokenizer_top sset_checker u_sset_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_token_kind   (rsp_if.token_kind),
   .rsp_token_byte   (rsp_if.token_byte),
   .rsp_default_name (rsp_if.default_name),
   .rsp_last         (rsp_if.last)
);

`default_nettype wire

// ===== verif/sse_token_checker.sv =====
// Token checker for the SSE event stream tokenizer: watches both channels and predicts tokens.
`timescale 1ns / 100ps

module sse_token_checker (
   input  wire logic clock,
   input  wire logic reset,
   sset_req_if       req_mon,
   sset_rsp_if       rsp_mon,
   output int        fail_count,
   output int        pending_count,
   output int        item_count,
   output int        token_count,
   output int        dispatch_count
);
   import sset_pkg::*;

   localparam logic ACT_FINISH = 1'b1;

   localparam logic [8*EVENT_LEN-1:0] EVENT_TAG = "event:";
   localparam logic [8*DATA_LEN-1:0]  DATA_TAG  = "data:";

   typedef enum logic [2:0] {
      LINE_START,
      LINE_PREFIX,
      LINE_BLANKS,
      LINE_VALUE,
      LINE_IGNORE
   } line_phase_type;

   typedef struct packed {
      tok_kind_type      kind;
      logic [BYTE_W-1:0] tbyte;
      logic              dflt;
      logic              last;
   } sse_token_type;

   // Line state of the tokenizer as seen from outside
   line_phase_type line_phase;
   logic [2:0]     prefix_pos;
   logic           data_line;
   logic           cr_pending;
   logic           data_seen;
   logic           name_seen;

   sse_token_type  item_tokens[$];
   sse_token_type  expected_tokens[$];

   // Queue one token for the current item; at most two per item
   function automatic void push_token(tok_kind_type kind, logic [BYTE_W-1:0] b, logic dflt);
      sse_token_type t;
      if (item_tokens.size() < 2) begin
         t.kind  = kind;
         t.tbyte = b;
         t.dflt  = dflt;
         t.last  = 1'b0;
         item_tokens.push_back(t);
      end
   endfunction

   function automatic void restart_line();
      line_phase = LINE_START;
      prefix_pos = '0;
      cr_pending = 1'b0;
   endfunction

   function automatic void add_value(logic [BYTE_W-1:0] b);
      if (data_line) begin
         push_token(TK_DATA, b, 1'b0);
         data_seen = 1'b1;
      end else begin
         push_token(TK_EVENT, b, 1'b0);
         name_seen = 1'b1;
      end
   endfunction

   // A blank line dispatches whatever has been collected
   function automatic void end_blank_line();
      if (data_seen || name_seen) begin
         push_token(TK_DISPATCH, '0, 1'b0);
         data_seen = 1'b0;
         name_seen = 1'b0;
      end
   endfunction

   // Value byte: hold a CR back until the next byte shows it is not a line end
   function automatic void take_value_byte(logic [BYTE_W-1:0] b);
      if (b == CH_LF) begin
         restart_line();
      end else if (b == CH_CR) begin
         if (cr_pending) add_value(CH_CR);
         cr_pending = 1'b1;
      end else begin
         if (cr_pending) begin
            add_value(CH_CR);
            cr_pending = 1'b0;
         end
         add_value(b);
      end
   endfunction

   // Work out the tokens of one accepted item and queue them as expected
   function automatic void tokenize_item(logic act, logic [BYTE_W-1:0] b);
      int                plen;
      int                pos;
      int                final_idx;
      logic [BYTE_W-1:0] want;
      sse_token_type     t;
      item_tokens.delete();
      if (act == ACT_FINISH) begin
         // close the stream: a lone CR at line start is a blank line
         if (line_phase == LINE_START && cr_pending) end_blank_line();
         restart_line();
         if (data_seen) begin
            push_token(TK_DISPATCH, '0, 1'b1);
            data_seen = 1'b0;
            name_seen = 1'b0;
         end
      end else begin
         case (line_phase)
            LINE_START: begin
               if (cr_pending) begin
                  cr_pending = 1'b0;
                  if (b == CH_LF) end_blank_line();
                  else line_phase = LINE_IGNORE;
               end else if (b == CH_LF) begin
                  end_blank_line();
               end else if (b == CH_CR) begin
                  cr_pending = 1'b1;
               end else if (b == EVENT_TAG[8*EVENT_LEN-1 -: 8]) begin
                  line_phase = LINE_PREFIX;
                  data_line  = 1'b0;
                  prefix_pos = 3'd1;
               end else if (b == DATA_TAG[8*DATA_LEN-1 -: 8]) begin
                  line_phase = LINE_PREFIX;
                  data_line  = 1'b1;
                  prefix_pos = 3'd1;
               end else begin
                  line_phase = LINE_IGNORE;
               end
            end
            LINE_PREFIX: begin
               plen = data_line ? DATA_LEN : EVENT_LEN;
               pos  = int'(prefix_pos);
               want = '0;
               if (pos < plen) begin
                  if (data_line) want = DATA_TAG[8*(DATA_LEN-1-pos) +: 8];
                  else want = EVENT_TAG[8*(EVENT_LEN-1-pos) +: 8];
               end
               if (pos < plen && b == want) begin
                  prefix_pos = prefix_pos + 3'd1;
                  if (int'(prefix_pos) == plen) begin
                     line_phase = LINE_BLANKS;
                     cr_pending = 1'b0;
                     if (!data_line) begin
                        push_token(TK_RESTART, '0, 1'b0);
                        name_seen = 1'b0;
                     end else if (data_seen) begin
                        push_token(TK_DATA, CH_LF, 1'b0);
                     end
                  end
               end else if (b == CH_LF) begin
                  restart_line();
               end else begin
                  line_phase = LINE_IGNORE;
               end
            end
            LINE_BLANKS: begin
               if (cr_pending) begin
                  if (b == CH_LF) begin
                     restart_line();
                  end else begin
                     cr_pending = 1'b0;
                     add_value(CH_CR);
                     line_phase = LINE_VALUE;
                     take_value_byte(b);
                  end
               end else if (b == CH_SPACE || b == CH_TAB) begin
                  // skip leading blanks of the value
               end else if (b == CH_LF) begin
                  restart_line();
               end else if (b == CH_CR) begin
                  cr_pending = 1'b1;
               end else begin
                  line_phase = LINE_VALUE;
                  add_value(b);
               end
            end
            LINE_VALUE: begin
               take_value_byte(b);
            end
            default: begin
               line_phase = LINE_IGNORE;
               cr_pending = 1'b0;
               if (b == CH_LF) restart_line();
            end
         endcase
      end
      // mark the final token of the item and move it to the expected queue
      if (item_tokens.size() > 0) begin
         final_idx              = item_tokens.size() - 1;
         t                      = item_tokens[final_idx];
         t.last                 = 1'b1;
         item_tokens[final_idx] = t;
      end
      foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Predict on each input transfer, compare on each output transfer
   always @(posedge clock) begin : watch
      sse_token_type exp_tok;
      if (reset) begin
         expected_tokens.delete();
         restart_line();
         data_line      = 1'b0;
         data_seen      = 1'b0;
         name_seen      = 1'b0;
         fail_count     = 0;
         item_count     = 0;
         token_count    = 0;
         dispatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            item_count++;
            tokenize_item(req_mon.action, req_mon.in_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            token_count++;
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d byte 0x%0h", rsp_mon.token_kind,
                      rsp_mon.token_byte);
               fail_count++;
            end else begin
               exp_tok = expected_tokens.pop_front();
               if (exp_tok.kind == TK_DISPATCH) dispatch_count++;
               check_field("token_kind", 32'(exp_tok.kind), 32'(rsp_mon.token_kind));
               check_field("token_byte", 32'(exp_tok.tbyte), 32'(rsp_mon.token_byte));
               check_field("default_name", 32'(exp_tok.dflt), 32'(rsp_mon.default_name));
               check_field("last", 32'(exp_tok.last), 32'(rsp_mon.last));
            end
         end
      end
      pending_count = expected_tokens.size();
   end

endmodule

// ===== verif/sse_event_stream_tokenizer_top_tb.sv =====
// Testbench top for the SSE event stream tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sse_event_stream_tokenizer_top_tb;
   import sset_pkg::*;

   localparam logic ACT_BYTE       = 1'b0;
   localparam logic ACT_FINISH     = 1'b1;
   localparam int   DIRECTED_ITEMS = 30;
   localparam int   PHASE_ITEMS    = 365;
   localparam int   LONG_HOLD      = 300;

   logic clock;
   logic reset;

   int fail_count;
   int pending_count;
   int item_count;
   int token_count;
   int dispatch_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int sent_items     = 0;
   int hold_requests  = 0;

   sset_req_if req_ch ();
   sset_rsp_if rsp_ch ();

   sse_event_stream_tokenizer_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sse_token_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .item_count     (item_count),
      .token_count    (token_count),
      .dispatch_count (dispatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Guard against a hung run
   initial begin
      #5_000_000;
      $display("sse_event_stream_tokenizer_top_tb failed");
      $finish;
   end

   // Drive output ready: random stalls, plus a long hold when asked for
   initial begin : rsp_drive
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one item at the falling edge and hold it until the transfer
   task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
   endtask

   // Field prefix, now and then with one byte spoilt
   task automatic send_prefix(input string s);
      int bad;
      bad = ($urandom_range(99) < 15) ? $urandom_range(s.len() - 1) : -1;
      for (int i = 0; i < s.len(); i++) begin
         if (i == bad) send_item(ACT_BYTE, 8'($urandom_range(255)));
         else send_item(ACT_BYTE, s[i]);
      end
   endtask

   // Value bytes: mostly printable, some of any value, some CR
   task automatic send_value();
      int pick;
      repeat ($urandom_range(8)) begin
         pick = $urandom_range(99);
         if (pick < 60) send_item(ACT_BYTE, 8'($urandom_range(126, 32)));
         else if (pick < 85) send_item(ACT_BYTE, 8'($urandom_range(255)));
         else send_item(ACT_BYTE, CH_CR);
      end
   endtask

   task automatic send_line_end();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) begin
         send_item(ACT_BYTE, CH_LF);
      end else if (pick < 8) begin
         send_item(ACT_BYTE, CH_CR);
         send_item(ACT_BYTE, CH_LF);
      end else if (pick == 8) begin
         send_item(ACT_BYTE, CH_CR);
      end
   endtask

   // One random line: mostly well-formed fields, else blanks, finishes, comments, id lines and noise
   task automatic send_random_line();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if (pick < 32) send_prefix("data:");
         else send_prefix("event:");
         repeat ($urandom_range(2)) send_item(ACT_BYTE, $urandom_range(1) ? CH_SPACE : CH_TAB);
         send_value();
         send_line_end();
      end else if (pick < 68) begin
         send_line_end();
      end else if (pick < 74) begin
         send_item(ACT_FINISH, 8'($urandom_range(255)));
      end else if (pick < 82) begin
         send_item(ACT_BYTE, CH_COLON);
         send_value();
         send_line_end();
      end else if (pick < 90) begin
         send_text("id:");
         send_value();
         send_line_end();
      end else begin
         repeat ($urandom_range(6, 1)) send_item(ACT_BYTE, 8'($urandom_range(255)));
      end
   endtask

   // Pause the sender until every expected token has arrived
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_BYTE;
      req_ch.in_byte = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: blanks skipped, held CR as value, CRLF dropped, extreme bytes
      send_text("data: ");
      send_item(ACT_BYTE, 8'hFF);
      send_item(ACT_BYTE, CH_CR);
      send_item(ACT_BYTE, 8'h00);
      send_item(ACT_BYTE, CH_CR);
      send_item(ACT_BYTE, CH_LF);
      // second data line joins with a separator; finish closes and dispatches
      send_text("data:");
      send_item(ACT_BYTE, 8'h7F);
      send_item(ACT_FINISH, 8'h00);
      // CR at line start not followed by LF ignores the line
      send_item(ACT_BYTE, CH_CR);
      send_text("q\n");
      // event name restart, then a lone CR closed by finish counts as blank
      send_text("event:");
      send_item(ACT_BYTE, 8'h80);
      send_item(ACT_BYTE, CH_LF);
      send_item(ACT_BYTE, CH_CR);
      send_item(ACT_FINISH, 8'hFF);
      drain_results();

      // Random phases with different idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 53;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 53;
            end
            default: begin
               send_idle_pct  = 21;
               recv_stall_pct = 21;
            end
         endcase
         if (phase == 0) begin
            // hold the output off while a dense burst fills the token queue
            hold_requests++;
            repeat (5) begin
               send_text("data:");
               repeat (6) send_item(ACT_BYTE, 8'($urandom_range(126, 33)));
               send_item(ACT_BYTE, CH_LF);
            end
         end
         while (sent_items < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) send_random_line();
         send_item(ACT_FINISH, 8'($urandom_range(255)));
         drain_results();
      end

      repeat (20) @(posedge clock);
      $display("Run covered %0d stream items and %0d tokens, %0d of them dispatches,",
               item_count, token_count, dispatch_count);
      $display("over four idling mixes, a long output hold and drained pauses between phases.");
      if (fail_count == 0) begin
         $display("sse_event_stream_tokenizer_top_tb passed");
      end else begin
         $display("sse_event_stream_tokenizer_top_tb failed");
      end
      $finish;
   end

endmodule
